// ===== src/llt_pkg.sv =====
// Shared types, codes and keyword tables for the logic language tokenizer.
`default_nettype none
package llt_pkg;

  localparam int unsigned LengthBitsDef = 16;
  localparam int unsigned OffsetBitsDef = 20;
  localparam int unsigned PosBits = 16;
  localparam int unsigned KindBits = 5;
  localparam int unsigned NumKw = 9;
  localparam int unsigned MaxRes = 3;

  typedef enum logic [3:0] {
    MODE_IDLE, MODE_MINUS, MODE_LESS, MODE_LESS_MINUS, MODE_GREATER,
    MODE_EQUAL, MODE_BANG, MODE_INT, MODE_IDENT
  } mode_e;

  typedef enum logic [KindBits-1:0] {
    K_LPAREN = 5'd0, K_RPAREN = 5'd1, K_COLON = 5'd2, K_DOT = 5'd3,
    K_EQEQ = 5'd4, K_NE = 5'd5, K_PLUS = 5'd6, K_IMP = 5'd7, K_MINUS = 5'd8,
    K_IFF = 5'd9, K_LE = 5'd10, K_LESS = 5'd11, K_GE = 5'd12,
    K_GREATER = 5'd13, K_INT = 5'd14, K_IDENT = 5'd15, K_KW0 = 5'd16,
    K_INVALID = 5'd25
  } kind_e;

  // Pending-token slot: which kind and whether its start is shifted by one.
  typedef struct packed {
    logic        valid;
    logic [4:0]  kind;
    logic        shift;   // split '-' after a failed "<-"
    logic [1:0]  len_sel; // 0: counter, 1..3 constant length
  } slot_t;

  // Keyword character at a position, 0 past the end.
  function automatic logic [7:0] kw_char(input int unsigned k, input int unsigned i);
    string s;
    case (k)
      0: s = "and";
      1: s = "or";
      2: s = "not";
      3: s = "true";
      4: s = "false";
      5: s = "forall";
      6: s = "exists";
      7: s = "bool";
      default: s = "int";
    endcase
    kw_char = (i < s.len()) ? s[i] : 8'd0;
  endfunction

  function automatic logic [2:0] kw_len(input int unsigned k);
    case (k)
      0: kw_len = 3'd3;
      1: kw_len = 3'd2;
      2: kw_len = 3'd3;
      3: kw_len = 3'd4;
      4: kw_len = 3'd5;
      5: kw_len = 3'd6;
      6: kw_len = 3'd6;
      7: kw_len = 3'd4;
      default: kw_len = 3'd3;
    endcase
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    is_alpha = ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
  endfunction

endpackage
`default_nettype wire

// ===== src/llt_ram.sv =====
// Generic single-port-write, registered-read RAM.
`default_nettype none
module llt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== src/llt_front.sv =====
// Front end: tracks position and scan state, classifies each byte into up to three tokens.
`default_nettype none
module llt_front import llt_pkg::*; #(
  parameter int unsigned LengthBits = LengthBitsDef,
  parameter int unsigned OffsetBits = OffsetBitsDef,
  localparam int unsigned TokW = KindBits + 2*PosBits + OffsetBits + LengthBits + 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic [7:0]        char_byte_i,
  input  wire logic              last_char_i,
  output logic [MaxRes-1:0]      tok_valid_o,
  output logic [TokW-1:0]        tok_o [MaxRes]
);
  localparam logic [PosBits-1:0]    PosMax = '1;
  localparam logic [OffsetBits-1:0] OffMax = '1;
  localparam logic [LengthBits-1:0] LenMax = '1;

  mode_e                  mode_q, mode_d;
  logic [PosBits-1:0]     line_q, line_d, col_q, col_d, sline_q, sline_d, scol_q, scol_d;
  logic [OffsetBits-1:0]  off_q, off_d, soff_q, soff_d;
  logic [LengthBits-1:0]  len_q, len_d;
  logic [NumKw-1:0]       cand_q, cand_d;

  logic [7:0] c;
  logic       fin;
  assign c = char_byte_i;
  assign fin = last_char_i;

  function automatic logic [PosBits-1:0] pinc(input logic [PosBits-1:0] v);
    pinc = (v == PosMax) ? v : v + 1'b1;
  endfunction
  function automatic logic [OffsetBits-1:0] oinc(input logic [OffsetBits-1:0] v);
    oinc = (v == OffMax) ? v : v + 1'b1;
  endfunction

  function automatic logic [NumKw-1:0] mask_next(input logic [NumKw-1:0] m,
      input logic [LengthBits-1:0] idx, input logic [7:0] ch);
    logic [NumKw-1:0] r;
    r = '0;
    for (int unsigned k = 0; k < NumKw; k++) begin
      if (m[k] && (idx < LengthBits'(kw_len(k))) && (idx < LengthBits'(6)) &&
          (kw_char(k, 32'(idx[2:0])) == ch)) begin
        r[k] = 1'b1;
      end
    end
    mask_next = r;
  endfunction

  function automatic logic [4:0] id_kind(input logic [NumKw-1:0] m,
      input logic [LengthBits-1:0] l);
    logic [4:0] r;
    r = K_IDENT;
    for (int k = NumKw - 1; k >= 0; k--) begin
      if (m[k] && (l == LengthBits'(kw_len(k)))) r = 5'(K_KW0 + k);
    end
    id_kind = r;
  endfunction

  // Token records built combinationally, up to three per byte.
  logic [MaxRes-1:0] tv;
  logic [4:0]            tk [MaxRes];
  logic [PosBits-1:0]    tl [MaxRes], tc [MaxRes];
  logic [OffsetBits-1:0] to [MaxRes];
  logic [LengthBits-1:0] tn [MaxRes];
  logic [1:0]            cnt;

  always_comb begin
    mode_e m;
    logic [PosBits-1:0] bl, bc, fl, fc;
    logic [OffsetBits-1:0] bo, fo;
    logic [LengthBits-1:0] bn;
    logic [NumKw-1:0] bm;
    logic do_begin;
    tv = '0;
    cnt = '0;
    for (int i = 0; i < MaxRes; i++) begin
      tk[i] = '0; tl[i] = '0; tc[i] = '0; to[i] = '0; tn[i] = '0;
    end
    m = mode_q;
    bl = sline_q; bc = scol_q; bo = soff_q; bn = len_q; bm = cand_q;
    do_begin = 1'b0;

    case (mode_q)
      MODE_MINUS: begin
        if (c == 8'h3e) begin
          tv[0] = 1'b1; tk[0] = K_IMP; tn[0] = LengthBits'(2); m = MODE_IDLE;
        end else begin
          tv[0] = 1'b1; tk[0] = K_MINUS; tn[0] = LengthBits'(1); do_begin = 1'b1;
        end
      end
      MODE_LESS: begin
        if (c == 8'h2d) begin
          m = MODE_LESS_MINUS; bn = LengthBits'(2);
        end else if (c == 8'h3d) begin
          tv[0] = 1'b1; tk[0] = K_LE; tn[0] = LengthBits'(2); m = MODE_IDLE;
        end else begin
          tv[0] = 1'b1; tk[0] = K_LESS; tn[0] = LengthBits'(1); do_begin = 1'b1;
        end
      end
      MODE_LESS_MINUS: begin
        if (c == 8'h3e) begin
          tv[0] = 1'b1; tk[0] = K_IFF; tn[0] = LengthBits'(3); m = MODE_IDLE;
        end else begin
          tv[1:0] = 2'b11; tk[0] = K_LESS; tn[0] = LengthBits'(1);
          tk[1] = K_MINUS; tn[1] = LengthBits'(1); do_begin = 1'b1;
        end
      end
      MODE_GREATER: begin
        if (c == 8'h3d) begin
          tv[0] = 1'b1; tk[0] = K_GE; tn[0] = LengthBits'(2); m = MODE_IDLE;
        end else begin
          tv[0] = 1'b1; tk[0] = K_GREATER; tn[0] = LengthBits'(1); do_begin = 1'b1;
        end
      end
      MODE_EQUAL, MODE_BANG: begin
        if (c == 8'h3d) begin
          tv[0] = 1'b1; tk[0] = (mode_q == MODE_EQUAL) ? K_EQEQ : K_NE;
          tn[0] = LengthBits'(2); m = MODE_IDLE;
        end else begin
          tv[0] = 1'b1; tk[0] = K_INVALID; tn[0] = LengthBits'(1); do_begin = 1'b1;
        end
      end
      MODE_INT: begin
        if (is_digit(c)) begin
          bn = (len_q == LenMax) ? len_q : len_q + 1'b1;
        end else begin
          tv[0] = 1'b1; tk[0] = K_INT; tn[0] = len_q; do_begin = 1'b1;
        end
      end
      MODE_IDENT: begin
        if (is_alpha(c) || is_digit(c) || c == 8'h5f) begin
          bm = mask_next(cand_q, len_q, c);
          bn = (len_q == LenMax) ? len_q : len_q + 1'b1;
        end else begin
          tv[0] = 1'b1; tk[0] = id_kind(cand_q, len_q); tn[0] = len_q; do_begin = 1'b1;
        end
      end
      default: do_begin = 1'b1;
    endcase
    // Tokens emitted from the pending slot carry its start position.
    for (int i = 0; i < 2; i++) begin
      tl[i] = sline_q; tc[i] = scol_q; to[i] = soff_q;
    end
    tc[1] = pinc(scol_q); to[1] = oinc(soff_q);

    if (do_begin) begin
      bl = line_q; bc = col_q; bo = off_q; bn = LengthBits'(1); m = MODE_IDLE;
      case (c)
        8'h20, 8'h09, 8'h0a: m = MODE_IDLE;
        8'h2d: m = MODE_MINUS;
        8'h3c: m = MODE_LESS;
        8'h3e: m = MODE_GREATER;
        8'h3d: m = MODE_EQUAL;
        8'h21: m = MODE_BANG;
        8'h28, 8'h29, 8'h3a, 8'h2e, 8'h2b: begin
          cnt = tv[1] ? 2'd2 : (tv[0] ? 2'd1 : 2'd0);
          tv[cnt] = 1'b1; tl[cnt] = bl; tc[cnt] = bc; to[cnt] = bo;
          tn[cnt] = LengthBits'(1);
          case (c)
            8'h28:   tk[cnt] = K_LPAREN;
            8'h29:   tk[cnt] = K_RPAREN;
            8'h3a:   tk[cnt] = K_COLON;
            8'h2e:   tk[cnt] = K_DOT;
            default: tk[cnt] = K_PLUS;
          endcase
        end
        default: begin
          if (is_digit(c)) begin
            m = MODE_INT;
          end else if (is_alpha(c)) begin
            m = MODE_IDENT;
            bm = mask_next('1, '0, c);
          end else begin
            cnt = tv[1] ? 2'd2 : (tv[0] ? 2'd1 : 2'd0);
            tv[cnt] = 1'b1; tk[cnt] = K_INVALID; tl[cnt] = bl; tc[cnt] = bc;
            to[cnt] = bo; tn[cnt] = LengthBits'(1);
          end
        end
      endcase
    end

    // Flush of the pending token after the final byte.
    fl = bl; fc = bc; fo = bo;
    if (fin) begin
      cnt = tv[1] ? 2'd2 : (tv[0] ? 2'd1 : 2'd0);
      case (m)
        MODE_MINUS, MODE_LESS, MODE_GREATER, MODE_EQUAL, MODE_BANG: begin
          tv[cnt] = 1'b1; tl[cnt] = fl; tc[cnt] = fc; to[cnt] = fo;
          tn[cnt] = LengthBits'(1);
          tk[cnt] = (m == MODE_MINUS) ? K_MINUS : (m == MODE_LESS) ? K_LESS :
                    (m == MODE_GREATER) ? K_GREATER : K_INVALID;
        end
        MODE_LESS_MINUS: begin
          // Only reachable without a begin, so slots 0 and 1 are free.
          tv[1:0] = 2'b11; tk[0] = K_LESS; tn[0] = LengthBits'(1);
          tl[0] = fl; tc[0] = fc; to[0] = fo;
          tk[1] = K_MINUS; tn[1] = LengthBits'(1);
          tl[1] = fl; tc[1] = pinc(fc); to[1] = oinc(fo);
        end
        MODE_INT, MODE_IDENT: begin
          tv[cnt] = 1'b1; tl[cnt] = fl; tc[cnt] = fc; to[cnt] = fo; tn[cnt] = bn;
          tk[cnt] = (m == MODE_INT) ? K_INT : id_kind(bm, bn);
        end
        default: ;
      endcase
      m = MODE_IDLE;
    end

    mode_d = m; sline_d = bl; scol_d = bc; soff_d = bo; len_d = bn; cand_d = bm;
    line_d = (c == 8'h0a) ? pinc(line_q) : line_q;
    col_d = (c == 8'h0a) ? PosBits'(1) : pinc(col_q);
    off_d = oinc(off_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      line_q <= PosBits'(1); col_q <= PosBits'(1); off_q <= '0;
      sline_q <= PosBits'(1); scol_q <= PosBits'(1); soff_q <= '0;
      len_q <= '0; cand_q <= '1;
      tok_valid_o <= '0;
    end else begin
      tok_valid_o <= '0;
      if (en_i) begin
        mode_q <= mode_d;
        line_q <= line_d; col_q <= col_d; off_q <= off_d;
        sline_q <= sline_d; scol_q <= scol_d; soff_q <= soff_d;
        len_q <= len_d; cand_q <= cand_d;
        tok_valid_o <= tv;
      end
    end
  end

  // Last-of-run is set on the highest valid record.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < MaxRes; i++) begin
        tok_o[i] <= {tk[i], tl[i], tc[i], to[i], tn[i],
                     (i == MaxRes - 1) ? tv[i] : (tv[i] && !tv[i+1 < MaxRes ? i+1 : i])};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
    end else begin
      assert (!(tv[2] && !tv[1])) else $error("token slots not packed");
    end
  end

  a_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tv[1] |-> tv[0]) else $error("token slots out of order");
  a_idle_after_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && fin) |=> mode_q == MODE_IDLE) else $error("pending token after final byte");
  a_col_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && c == 8'h0a) |=> col_q == PosBits'(1)) else $error("column not reset on newline");
endmodule
`default_nettype wire

// ===== src/llt_back.sv =====
// Back end: token queue in RAM banks, written up to three beats per cycle, read one per pop.
`default_nettype none
module llt_back import llt_pkg::*; #(
  parameter int unsigned TokW = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [MaxRes-1:0] tok_valid_i,
  input  wire logic [TokW-1:0]   tok_i [MaxRes],
  output logic                   space_o,
  output logic                   empty_o,
  input  wire logic              pop_i,
  output logic [TokW-1:0]        head_o
);
  localparam int unsigned AW = $clog2(Depth);

  // Three banks, each a RAM, written round-robin so up to three beats land per cycle.
  logic [AW-1:0]   wp_q [MaxRes];
  logic [AW-1:0]   rp_q [MaxRes];
  logic [1:0]      wb_q, rb_q;
  logic [AW+2:0]   cnt_q;
  logic [TokW-1:0] rd [MaxRes];
  logic [MaxRes-1:0] we;
  logic [AW-1:0]   wa [MaxRes];
  logic [TokW-1:0] wd [MaxRes];
  logic [1:0]      nin;
  logic [2:0]      wsum;
  logic            deq;
  // Output register holding the head beat.
  logic            hv_q;
  logic [TokW-1:0] head_q;
  logic            rd_pend_q;
  logic [1:0]      rd_bank_q;

  always_comb begin
    logic [1:0] b;
    logic [2:0] s;
    nin = 2'(tok_valid_i[0]) + 2'(tok_valid_i[1]) + 2'(tok_valid_i[2]);
    we = '0;
    for (int i = 0; i < MaxRes; i++) begin
      wa[i] = wp_q[i]; wd[i] = tok_i[0];
    end
    for (int j = 0; j < MaxRes; j++) begin
      s = 3'(wb_q) + 3'(j);
      b = (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
      if (tok_valid_i[j]) begin
        we[b] = 1'b1; wd[b] = tok_i[j];
      end
    end
  end

  // The bank pointer sum never exceeds five, so one subtraction wraps it.
  assign wsum = 3'(wb_q) + 3'(nin);

  for (genvar g = 0; g < MaxRes; g++) begin : g_bank
    llt_ram #(.Width(TokW), .Depth(Depth)) u_ram (
      .clk_i, .we_i(we[g]), .waddr_i(wa[g]), .wdata_i(wd[g]),
      .raddr_i(rp_q[g]), .rdata_o(rd[g])
    );
  end

  // A read is issued when the head register will be free and the RAM holds data
  // not yet in flight; bypass-free, so a beat passes the RAM read register, then the head register.
  logic issue;
  logic [AW+2:0] stored;
  assign stored = cnt_q;
  assign deq = hv_q && pop_i;
  assign issue = (stored != '0) && !rd_pend_q && (!hv_q || deq);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxRes; i++) begin
        wp_q[i] <= '0; rp_q[i] <= '0;
      end
      wb_q <= '0; rb_q <= '0; cnt_q <= '0;
      hv_q <= 1'b0; rd_pend_q <= 1'b0; rd_bank_q <= '0;
    end else begin
      for (int i = 0; i < MaxRes; i++) begin
        if (we[i]) wp_q[i] <= wp_q[i] + 1'b1;
      end
      wb_q <= (wsum >= 3'd3) ? 2'(wsum - 3'd3) : wsum[1:0];
      cnt_q <= cnt_q + (AW+3)'(nin) - (AW+3)'(issue);
      rd_pend_q <= issue;
      if (issue) begin
        rp_q[rb_q] <= rp_q[rb_q] + 1'b1;
        rd_bank_q <= rb_q;
        rb_q <= (rb_q == 2'(MaxRes - 1)) ? '0 : rb_q + 1'b1;
      end
      if (rd_pend_q) hv_q <= 1'b1;
      else if (deq) hv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_pend_q) head_q <= rd[rd_bank_q];
  end

  assign empty_o = !hv_q;
  assign head_o = head_q;
  // Room for a worst-case byte plus beats already in flight.
  assign space_o = cnt_q <= (AW+3)'(MaxRes * Depth - 2 * MaxRes);

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (AW+3)'(MaxRes * Depth)) else $error("token queue overflow");
  a_read_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |=> hv_q == 1'b0 || $past(deq)) else $error("read into occupied head");
  a_pend_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |=> hv_q) else $error("head not filled after read");
endmodule
`default_nettype wire

// ===== src/logic_language_tokenizer_top.sv =====
// Top level of the logic language tokenizer: front classifier feeding a token queue.
// Throughput: one source byte per cycle while the queue has room for a byte's worth;
// results cannot leave back to back, since each head refill takes a RAM read and only one read is in flight.
// A token caused by a byte reaches the result ports through the front register, the RAM
// read and the head register; a head register that is still occupied holds it back.
// Reset is asynchronous, active low; position starts at line 1, column 1, offset 0.
`default_nettype none
module logic_language_tokenizer_top import llt_pkg::*; #(
  parameter int unsigned LengthBits = LengthBitsDef,
  parameter int unsigned OffsetBits = OffsetBitsDef
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic [7:0]            char_byte_i,
  input  wire logic                  last_char_i,
  output logic                       empty,
  input  wire logic                  pop,
  output logic [KindBits-1:0]        token_kind_o,
  output logic [PosBits-1:0]         start_line_o,
  output logic [PosBits-1:0]         start_column_o,
  output logic [OffsetBits-1:0]      start_offset_o,
  output logic [LengthBits-1:0]      token_length_o,
  output logic                       last_of_run_o
);
  localparam int unsigned TokW = KindBits + 2*PosBits + OffsetBits + LengthBits + 1;

  logic [MaxRes-1:0] tv;
  logic [TokW-1:0]   tok [MaxRes];
  logic              space;
  logic [TokW-1:0]   head;

  llt_front #(.LengthBits(LengthBits), .OffsetBits(OffsetBits)) u_front (
    .clk_i, .rst_ni, .en_i(push && !full), .char_byte_i, .last_char_i,
    .tok_valid_o(tv), .tok_o(tok)
  );

  llt_back #(.TokW(TokW), .Depth(16)) u_back (
    .clk_i, .rst_ni, .tok_valid_i(tv), .tok_i(tok), .space_o(space),
    .empty_o(empty), .pop_i(pop), .head_o(head)
  );

  assign full = !space;
  assign {token_kind_o, start_line_o, start_column_o, start_offset_o,
          token_length_o, last_of_run_o} = head;
endmodule
`default_nettype wire
